FILE: sv/tpr_pkg.sv
`default_nettype none

package tpr_pkg;

	localparam int ADC_BITS   = 12;
	localparam int TIME_BITS  = 32;
	localparam int POS_BITS   = 16;
	localparam int RATE_BITS  = 32;
	localparam int FAIL_BITS  = 14;
	localparam int FS_BITS    = 14;
	localparam int US_BITS    = 20;
	localparam int CFG_IDX_BITS  = 2;
	localparam int CFG_DATA_BITS = (ADC_BITS > FAIL_BITS) ? ADC_BITS : FAIL_BITS;

	// full scale and microseconds per second
	localparam logic [FS_BITS-1:0] FULL_SCALE = FS_BITS'(10000);
	localparam logic [US_BITS-1:0] US_PER_S   = US_BITS'(1000000);

	// shared divider: widest numerator is |delta| * 1e6
	localparam int NUM1_BITS  = ADC_BITS + FS_BITS;
	localparam int DIV_N_BITS = POS_BITS + US_BITS;
	localparam int DIV_D_BITS = TIME_BITS;
	localparam int DIV_SHIFT1 = DIV_N_BITS - NUM1_BITS;
	localparam int CNT_BITS   = $clog2(DIV_N_BITS + 1);

	localparam int STEP_BITS = 3;

	typedef logic [STEP_BITS-1:0] step_t;

	localparam step_t ST_WAIT  = 3'd0;
	localparam step_t ST_PREP1 = 3'd1;
	localparam step_t ST_DIV1  = 3'd2;
	localparam step_t ST_POS   = 3'd3;
	localparam step_t ST_PREP2 = 3'd4;
	localparam step_t ST_DIV2  = 3'd5;
	localparam step_t ST_EMIT  = 3'd6;
	localparam step_t ST_FAIL  = 3'd7;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_CLOSED = 2'd0,
		REG_OPEN   = 2'd1,
		REG_INVERT = 2'd2,
		REG_FAIL   = 2'd3
	} cfg_reg_t;

	typedef enum logic [2:0] {
		OP_NOP   = 3'd0,
		OP_LATCH = 3'd1,
		OP_PREP1 = 3'd2,
		OP_DIV   = 3'd3,
		OP_POS   = 3'd4,
		OP_PREP2 = 3'd5,
		OP_EMIT  = 3'd6,
		OP_FAIL  = 3'd7
	} op_t;

	typedef enum logic [2:0] {
		CND_NEVER    = 3'd0,
		CND_NO_REQ   = 3'd1,
		CND_CAL_BAD  = 3'd2,
		CND_DIV_MORE = 3'd3,
		CND_DT_ZERO  = 3'd4,
		CND_OUT_BUSY = 3'd5
	} cond_t;

	// hold: the op is suppressed while the condition is true
	typedef struct packed {
		op_t   op;
		cond_t cond;
		logic  hold;
		step_t jmp;
		step_t nxt;
	} uword_t;

	typedef struct packed {
		logic no_req;
		logic cal_bad;
		logic div_more;
		logic dt_zero;
		logic out_busy;
	} flags_t;

	typedef struct packed {
		logic load;
		logic step;
	} div_ctl_t;

	function automatic uword_t ucode(input step_t s);
		uword_t w;
		case (s)
			ST_WAIT:  w = '{OP_LATCH, CND_NO_REQ,   1'b1, ST_WAIT,  ST_PREP1};
			ST_PREP1: w = '{OP_PREP1, CND_CAL_BAD,  1'b0, ST_FAIL,  ST_DIV1};
			ST_DIV1:  w = '{OP_DIV,   CND_DIV_MORE, 1'b0, ST_DIV1,  ST_POS};
			ST_POS:   w = '{OP_POS,   CND_NEVER,    1'b0, ST_WAIT,  ST_PREP2};
			ST_PREP2: w = '{OP_PREP2, CND_DT_ZERO,  1'b0, ST_EMIT,  ST_DIV2};
			ST_DIV2:  w = '{OP_DIV,   CND_DIV_MORE, 1'b0, ST_DIV2,  ST_EMIT};
			ST_EMIT:  w = '{OP_EMIT,  CND_OUT_BUSY, 1'b1, ST_EMIT,  ST_WAIT};
			ST_FAIL:  w = '{OP_FAIL,  CND_OUT_BUSY, 1'b1, ST_FAIL,  ST_WAIT};
			default:  w = '{OP_NOP,   CND_NEVER,    1'b0, ST_WAIT,  ST_WAIT};
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

FILE: sv/tpr_if.sv
`default_nettype none

interface tpr_in_if;
	logic                          valid;
	logic                          ready;
	logic [tpr_pkg::ADC_BITS-1:0]  adc_sample;
	logic [tpr_pkg::TIME_BITS-1:0] timestamp_us;

	modport source (output valid, adc_sample, timestamp_us, input ready);
	modport sink   (input valid, adc_sample, timestamp_us, output ready);
endinterface

interface tpr_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [tpr_pkg::POS_BITS-1:0]  position;
	logic signed [tpr_pkg::RATE_BITS-1:0] rate;
	logic                                 sensor_error;

	modport source (output valid, position, rate, sensor_error, input ready);
	modport sink   (input valid, position, rate, sensor_error, output ready);
endinterface

`default_nettype wire

FILE: sv/throttle_position_rate.sv
// a request runs two divisions on the shared divider: 26 quotient bits for the position, then 36 for the rate
// zero elapsed time skips the rate division
// one request in flight: the next is taken only after the last result is written; the divider is one-bit-per-cycle
// an uncalibrated request skips both divisions and gives the fail-safe value in position and rate
// a finished result waits in the output register while the next request is taken
// reset clears calibration registers, last position and last time to zero
`default_nettype none

module throttle_position_rate (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tpr_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [tpr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	tpr_in_if.sink                                   smp,
	tpr_out_if.source                                res
);

	// calibration registers
	logic [tpr_pkg::ADC_BITS-1:0]  closed_q;
	logic [tpr_pkg::ADC_BITS-1:0]  open_q;
	logic                          invert_q;
	logic [tpr_pkg::FAIL_BITS-1:0] fail_q;

	// request capture and kept state
	logic [tpr_pkg::ADC_BITS-1:0]  sample_q;
	logic [tpr_pkg::TIME_BITS-1:0] now_q;
	logic [tpr_pkg::POS_BITS-1:0]  last_pos_q;
	logic [tpr_pkg::TIME_BITS-1:0] last_time_q;

	// working registers between microcode steps
	logic                          sign1_q;
	logic [tpr_pkg::POS_BITS-1:0]  pos_q;
	logic [tpr_pkg::POS_BITS-1:0]  dmag_q;
	logic                          dsign_q;
	logic [tpr_pkg::TIME_BITS-1:0] dt_q;

	// output register
	logic                                 ov_q;
	logic signed [tpr_pkg::POS_BITS-1:0]  opos_q;
	logic signed [tpr_pkg::RATE_BITS-1:0] orate_q;
	logic                                 oerr_q;

	tpr_pkg::uword_t   uword;
	tpr_pkg::flags_t   flags;
	tpr_pkg::div_ctl_t div_ctl;
	logic              fire;
	logic              accept;
	logic              cal_bad;

	logic [tpr_pkg::DIV_N_BITS-1:0] div_quo;
	logic                           div_more;
	logic [tpr_pkg::DIV_N_BITS-1:0] ld_num;
	logic [tpr_pkg::DIV_D_BITS-1:0] ld_den;
	logic [tpr_pkg::CNT_BITS-1:0]   ld_cnt;

	// first division: (sample - lo) * full scale / (hi - lo), on magnitudes
	logic [tpr_pkg::ADC_BITS-1:0]  lo_c;
	logic [tpr_pkg::ADC_BITS-1:0]  hi_c;
	logic [tpr_pkg::ADC_BITS:0]    diff_c;
	logic [tpr_pkg::ADC_BITS:0]    span_c;
	logic [tpr_pkg::ADC_BITS-1:0]  diff_mag;
	logic [tpr_pkg::ADC_BITS-1:0]  span_mag;
	logic [tpr_pkg::NUM1_BITS-1:0] num1_c;

	// position and delta
	logic [tpr_pkg::NUM1_BITS-1:0] q1_c;
	logic [tpr_pkg::POS_BITS-1:0]  pos_c;
	logic [tpr_pkg::POS_BITS:0]    delta_c;
	logic [tpr_pkg::POS_BITS-1:0]  dmag_c;

	// second division: |delta| * 1e6 / dt
	logic [tpr_pkg::DIV_N_BITS-1:0] num2_c;
	logic [tpr_pkg::RATE_BITS-1:0]  rate_c;
	logic                           rate_big;

	localparam logic [tpr_pkg::NUM1_BITS-1:0] POS_NEG_LIM =
		tpr_pkg::NUM1_BITS'(1) << (tpr_pkg::POS_BITS - 1);
	localparam logic [tpr_pkg::NUM1_BITS-1:0] POS_POS_LIM = POS_NEG_LIM - 1'b1;
	localparam logic [tpr_pkg::DIV_N_BITS-1:0] RATE_LIM =
		tpr_pkg::DIV_N_BITS'(1) << (tpr_pkg::RATE_BITS - 1);
	localparam logic [tpr_pkg::POS_BITS-1:0]  POS_MAX  = {1'b0, {(tpr_pkg::POS_BITS-1){1'b1}}};
	localparam logic [tpr_pkg::POS_BITS-1:0]  POS_MIN  = {1'b1, {(tpr_pkg::POS_BITS-1){1'b0}}};
	localparam logic [tpr_pkg::RATE_BITS-1:0] RATE_MAX = {1'b0, {(tpr_pkg::RATE_BITS-1){1'b1}}};
	localparam logic [tpr_pkg::RATE_BITS-1:0] RATE_MIN = {1'b1, {(tpr_pkg::RATE_BITS-1){1'b0}}};

	// sequencer and shared divider
	tpr_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.flags  (flags),
		.uword  (uword),
		.fire   (fire)
	);

	tpr_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (div_ctl),
		.ld_num (ld_num),
		.ld_den (ld_den),
		.ld_cnt (ld_cnt),
		.quo    (div_quo),
		.more   (div_more)
	);

	// handshakes
	assign smp.ready = (uword.op == tpr_pkg::OP_LATCH);
	assign accept    = smp.valid && smp.ready;

	assign res.valid        = ov_q;
	assign res.position     = opos_q;
	assign res.rate         = orate_q;
	assign res.sensor_error = oerr_q;

	// equal counts (zero included) mean no usable span
	assign cal_bad = (closed_q == open_q);

	assign flags.no_req   = !smp.valid;
	assign flags.cal_bad  = cal_bad;
	assign flags.div_more = div_more;
	assign flags.dt_zero  = (dt_q == '0);
	assign flags.out_busy = ov_q && !res.ready;

	// ends swapped when inverted
	always_comb begin
		lo_c     = invert_q ? open_q : closed_q;
		hi_c     = invert_q ? closed_q : open_q;
		diff_c   = {1'b0, sample_q} - {1'b0, lo_c};
		span_c   = {1'b0, hi_c} - {1'b0, lo_c};
		diff_mag = diff_c[tpr_pkg::ADC_BITS] ? tpr_pkg::ADC_BITS'(-diff_c)
		                                     : diff_c[tpr_pkg::ADC_BITS-1:0];
		span_mag = span_c[tpr_pkg::ADC_BITS] ? tpr_pkg::ADC_BITS'(-span_c)
		                                     : span_c[tpr_pkg::ADC_BITS-1:0];
		num1_c   = tpr_pkg::NUM1_BITS'(diff_mag * tpr_pkg::FULL_SCALE);
	end

	// saturate the truncated quotient, then difference against last position
	always_comb begin
		q1_c = div_quo[tpr_pkg::NUM1_BITS-1:0];
		if (sign1_q) begin
			pos_c = (q1_c > POS_NEG_LIM) ? POS_MIN
			                             : tpr_pkg::POS_BITS'(-q1_c[tpr_pkg::POS_BITS-1:0]);
		end else begin
			pos_c = (q1_c > POS_POS_LIM) ? POS_MAX : q1_c[tpr_pkg::POS_BITS-1:0];
		end
		delta_c = {pos_c[tpr_pkg::POS_BITS-1], pos_c}
		        - {last_pos_q[tpr_pkg::POS_BITS-1], last_pos_q};
		dmag_c  = delta_c[tpr_pkg::POS_BITS] ? tpr_pkg::POS_BITS'(-delta_c)
		                                     : delta_c[tpr_pkg::POS_BITS-1:0];
	end

	assign num2_c = tpr_pkg::DIV_N_BITS'(dmag_q * tpr_pkg::US_PER_S);

	// rate clamp: zero dt gives zero; magnitude of 2^31 or more saturates, sign restored last
	always_comb begin
		rate_big = (div_quo >= RATE_LIM);
		if (flags.dt_zero) begin
			rate_c = '0;
		end else if (dsign_q) begin
			rate_c = rate_big ? RATE_MIN
			                  : tpr_pkg::RATE_BITS'(-div_quo[tpr_pkg::RATE_BITS-1:0]);
		end else begin
			rate_c = rate_big ? RATE_MAX : div_quo[tpr_pkg::RATE_BITS-1:0];
		end
	end

	// divider loads and steps under microcode control
	always_comb begin
		div_ctl.load = 1'b0;
		div_ctl.step = 1'b0;
		ld_num       = {num1_c, {tpr_pkg::DIV_SHIFT1{1'b0}}};
		ld_den       = tpr_pkg::DIV_D_BITS'(span_mag);
		ld_cnt       = tpr_pkg::CNT_BITS'(tpr_pkg::NUM1_BITS);
		case (uword.op)
			tpr_pkg::OP_PREP1: begin
				div_ctl.load = 1'b1;
			end
			tpr_pkg::OP_PREP2: begin
				div_ctl.load = 1'b1;
				ld_num       = num2_c;
				ld_den       = dt_q;
				ld_cnt       = tpr_pkg::CNT_BITS'(tpr_pkg::DIV_N_BITS);
			end
			tpr_pkg::OP_DIV: begin
				div_ctl.step = 1'b1;
			end
			default: begin
				div_ctl.load = 1'b0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			closed_q <= '0;
			open_q   <= '0;
			invert_q <= 1'b0;
			fail_q   <= '0;
		end else if (cfg_we) begin
			case (tpr_pkg::cfg_reg_t'(cfg_index))
				tpr_pkg::REG_CLOSED: closed_q <= cfg_data[tpr_pkg::ADC_BITS-1:0];
				tpr_pkg::REG_OPEN:   open_q   <= cfg_data[tpr_pkg::ADC_BITS-1:0];
				tpr_pkg::REG_INVERT: invert_q <= cfg_data[0];
				tpr_pkg::REG_FAIL:   fail_q   <= cfg_data[tpr_pkg::FAIL_BITS-1:0];
				default:             fail_q   <= fail_q;
			endcase
		end
	end

	// kept position and time, touched only on a calibrated request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_pos_q  <= '0;
			last_time_q <= '0;
		end else if (uword.op == tpr_pkg::OP_POS) begin
			last_pos_q  <= pos_c;
			last_time_q <= now_q;
		end
	end

	// payload working registers
	always_ff @(posedge clk) begin
		if (accept) begin
			sample_q <= smp.adc_sample;
			now_q    <= smp.timestamp_us;
		end
		if (uword.op == tpr_pkg::OP_PREP1) begin
			sign1_q <= diff_c[tpr_pkg::ADC_BITS] ^ span_c[tpr_pkg::ADC_BITS];
		end
		if (uword.op == tpr_pkg::OP_POS) begin
			pos_q   <= pos_c;
			dmag_q  <= dmag_c;
			dsign_q <= delta_c[tpr_pkg::POS_BITS];
			dt_q    <= now_q - last_time_q;
		end
	end

	// output register: a new result wins over the take of the old one
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ov_q <= 1'b0;
		end else if (fire && (uword.op == tpr_pkg::OP_EMIT || uword.op == tpr_pkg::OP_FAIL)) begin
			ov_q <= 1'b1;
		end else if (res.ready) begin
			ov_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && uword.op == tpr_pkg::OP_EMIT) begin
			opos_q  <= pos_q;
			orate_q <= rate_c;
			oerr_q  <= 1'b0;
		end else if (fire && uword.op == tpr_pkg::OP_FAIL) begin
			opos_q  <= tpr_pkg::POS_BITS'(fail_q);
			orate_q <= tpr_pkg::RATE_BITS'(fail_q);
			oerr_q  <= 1'b1;
		end
	end

	// one request in flight at a time
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !smp.ready)
		else $error("request taken while another is in flight");

	// fail-safe path leaves the kept state alone
	a_fail_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && uword.op == tpr_pkg::OP_FAIL) |=> ($stable(last_pos_q) && $stable(last_time_q)))
		else $error("kept state changed on uncalibrated request");

	// an error result carries the fail-safe value in both fields
	a_fail_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.sensor_error) |->
		(res.position == $signed(tpr_pkg::POS_BITS'(fail_q)) &&
		 res.rate == $signed(tpr_pkg::RATE_BITS'(fail_q))))
		else $error("error result without fail-safe value");

	// a result is never written while the divider still has steps to run
	a_emit_after_div: assert property (@(posedge clk) disable iff (!arst_n)
		(uword.op == tpr_pkg::OP_EMIT && !flags.dt_zero) |-> !div_more)
		else $error("result emitted before division finished");

endmodule

`default_nettype wire

FILE: sv/tpr_seq.sv
`default_nettype none

module tpr_seq (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire tpr_pkg::flags_t flags,
	output tpr_pkg::uword_t      uword,
	output logic                 fire
);

	tpr_pkg::step_t step_q;
	logic           cond_true;

	assign uword = tpr_pkg::ucode(step_q);

	always_comb begin
		case (uword.cond)
			tpr_pkg::CND_NEVER:    cond_true = 1'b0;
			tpr_pkg::CND_NO_REQ:   cond_true = flags.no_req;
			tpr_pkg::CND_CAL_BAD:  cond_true = flags.cal_bad;
			tpr_pkg::CND_DIV_MORE: cond_true = flags.div_more;
			tpr_pkg::CND_DT_ZERO:  cond_true = flags.dt_zero;
			tpr_pkg::CND_OUT_BUSY: cond_true = flags.out_busy;
			default:               cond_true = 1'b0;
		endcase
	end

	assign fire = !(uword.hold && cond_true);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= tpr_pkg::ST_WAIT;
		end else begin
			step_q <= cond_true ? uword.jmp : uword.nxt;
		end
	end

endmodule

`default_nettype wire

FILE: sv/tpr_div.sv
`default_nettype none

module tpr_div (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire tpr_pkg::div_ctl_t                ctl,
	input  wire logic [tpr_pkg::DIV_N_BITS-1:0]   ld_num,
	input  wire logic [tpr_pkg::DIV_D_BITS-1:0]   ld_den,
	input  wire logic [tpr_pkg::CNT_BITS-1:0]     ld_cnt,
	output logic [tpr_pkg::DIV_N_BITS-1:0]        quo,
	output logic                                  more
);

	// restoring divider, one quotient bit per step, numerator msb first
	logic [tpr_pkg::DIV_N_BITS-1:0] n_q;
	logic [tpr_pkg::DIV_D_BITS-1:0] d_q;
	logic [tpr_pkg::DIV_D_BITS-1:0] r_q;
	logic [tpr_pkg::DIV_N_BITS-1:0] q_q;
	logic [tpr_pkg::CNT_BITS-1:0]   cnt_q;
	logic [tpr_pkg::DIV_D_BITS:0]   r_sh;
	logic [tpr_pkg::DIV_D_BITS:0]   r_sub;
	logic                           q_bit;

	assign r_sh  = {r_q, n_q[tpr_pkg::DIV_N_BITS-1]};
	assign r_sub = r_sh - {1'b0, d_q};
	assign q_bit = !r_sub[tpr_pkg::DIV_D_BITS];

	assign quo  = q_q;
	assign more = (cnt_q > tpr_pkg::CNT_BITS'(1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (ctl.load) begin
			cnt_q <= ld_cnt;
		end else if (ctl.step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			n_q <= ld_num;
			d_q <= ld_den;
			r_q <= '0;
			q_q <= '0;
		end else if (ctl.step) begin
			n_q <= {n_q[tpr_pkg::DIV_N_BITS-2:0], 1'b0};
			r_q <= q_bit ? r_sub[tpr_pkg::DIV_D_BITS-1:0] : r_sh[tpr_pkg::DIV_D_BITS-1:0];
			q_q <= {q_q[tpr_pkg::DIV_N_BITS-2:0], q_bit};
		end
	end

endmodule

`default_nettype wire
